// ===== rtl/core/sctok_pkg.sv =====
// Shared types, constants and character/keyword helpers for the script tokenizer.
package sctok_pkg;

	localparam int MAX_TOKEN_LEN = 512;
	localparam int KEYWORD_CHARS = 8;
	localparam int LEN_W = 9;
	localparam int LEN_CAP = ((MAX_TOKEN_LEN - 1) > 511) ? 511 : (MAX_TOKEN_LEN - 1);
	localparam int KW_COUNT = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] K_EOF = 3'd0;
	localparam logic [2:0] K_DEF = 3'd1;
	localparam logic [2:0] K_IDF = 3'd2;
	localparam logic [2:0] K_BHD = 3'd3;
	localparam logic [2:0] K_NBR = 3'd4;
	localparam logic [2:0] K_SPR = 3'd5;
	localparam logic [2:0] K_MOP = 3'd6;
	localparam logic [2:0] K_LOP = 3'd7;

	typedef enum logic [2:0] {
		M_IDLE,
		M_IDENT,
		M_NUMBER,
		M_LOGIC,
		M_SLASH,
		M_LINE,
		M_BLOCK,
		M_STAR
	} mode_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [31:0]      offset;
		logic [LEN_W-1:0] length;
		logic             overflow;
		logic             last;
	} token_t;

	typedef struct packed {
		token_t     tok0;
		token_t     tok1;
		logic [1:0] count;
	} step_res_t;

	// Keyword text, right-justified: last character in the low byte.
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		64'("function"), 64'("var"), 64'("for"), 64'("foreach"),
		64'("else"), 64'("event"), 64'("do"), 64'("if"),
		64'("body"), 64'("while"), 64'("header"), 64'("document")
	};
	localparam int KW_LEN [KW_COUNT] = '{8, 3, 3, 7, 4, 5, 2, 2, 4, 5, 6, 8};
	localparam logic [2:0] KW_KIND [KW_COUNT] = '{
		K_DEF, K_DEF, K_BHD, K_BHD, K_BHD, K_BHD,
		K_BHD, K_BHD, K_BHD, K_BHD, K_BHD, K_BHD
	};

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c inside {8'd32, 8'd9, 8'd10, 8'd11, 8'd13};
	endfunction

	function automatic logic is_sep(logic [7:0] c);
		return c inside {"{", "}", "(", ")", "[", "]", ":", ";", ",", 8'h22, 8'h27};
	endfunction

	function automatic logic is_logic(logic [7:0] c);
		return c inside {">", "<", "=", "&", "|", "%"};
	endfunction

	function automatic logic is_math(logic [7:0] c);
		return c inside {"+", "-", "*", "^"};
	endfunction

	// Window byte j sits at bits [8j +: 8]; only bytes below len are compared.
	function automatic logic [2:0] kw_kind(logic [63:0] win, logic [LEN_W-1:0] len,
			logic ovf);
		logic [2:0] k;
		logic       hit;
		int         idx;
		k = K_IDF;
		for (int i = 0; i < KW_COUNT; i++) begin
			hit = (len == LEN_W'(KW_LEN[i]));
			for (int j = 0; j < KEYWORD_CHARS; j++) begin
				idx = (j < KW_LEN[i]) ? (KW_LEN[i] - 1 - j) : 0;
				if (j < KW_LEN[i] && win[8*j +: 8] != KW_TEXT[i][8*idx +: 8])
					hit = 1'b0;
			end
			if (hit)
				k = KW_KIND[i];
		end
		if (ovf)
			k = K_IDF;
		return k;
	endfunction

endpackage

// ===== rtl/core/sctok_fifo.sv =====
// Small result queue: takes up to two tokens per cycle, hands out one.
module sctok_fifo
	import sctok_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  token_t     push_tok0,
	input  token_t     push_tok1,
	input  logic       pop,
	output logic       room,
	output logic       not_empty,
	output token_t     head
);

	token_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     cnt_q;
	logic [QUEUE_AW-1:0]   wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + QUEUE_AW'(1);
	assign room = cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);
	assign not_empty = cnt_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_ptr_q] <= push_tok0;
		if (push_n == 2'd2)
			mem_q[wr_ptr_nx] <= push_tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QUEUE_AW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			cnt_q <= cnt_q + (QUEUE_AW + 1)'(push_n) - (QUEUE_AW + 1)'(pop);
		end
	end

endmodule

// ===== rtl/core/sctok_lexer.sv =====
// Lexer state and the per-byte step: mode machine, counters, keyword window.
module sctok_lexer
	import sctok_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] text_byte,
	output step_res_t  res
);

	mode_t            mode_q, mode_d;
	logic [31:0]      pos_q, pos_d;
	logic [31:0]      start_q, start_d;
	logic [LEN_W-1:0] run_q, run_d;
	logic [63:0]      win_q, win_d;
	logic [1:0]       per_q, per_d;
	logic             ovf_q, ovf_d;

	logic       fin, idle, app, eof_c, beg, idle_res;
	logic [2:0] fin_kind, idle_kind;
	mode_t      beg_mode;
	logic       is_word, is_num;
	token_t     fin_tok, second_tok;

	assign is_word = is_letter(text_byte) || is_digit(text_byte) || text_byte == ".";
	assign is_num = is_digit(text_byte) || text_byte == ".";

	// Next state
	always_comb begin
		mode_d = mode_q;
		start_d = start_q;
		run_d = run_q;
		win_d = win_q;
		per_d = per_q;
		ovf_d = ovf_q;
		fin = 1'b0;
		fin_kind = K_IDF;
		idle = 1'b0;
		app = 1'b0;
		eof_c = 1'b0;
		beg = 1'b0;
		beg_mode = M_IDLE;
		idle_res = 1'b0;
		idle_kind = K_IDF;

		case (mode_q)
			M_IDENT: begin
				if (is_word) begin
					app = 1'b1;
				end else begin
					fin = 1'b1;
					fin_kind = kw_kind(win_q, run_q, ovf_q);
					idle = 1'b1;
				end
			end
			M_NUMBER: begin
				if (is_num) begin
					app = 1'b1;
					if (text_byte == "." && per_q < 2'd2)
						per_d = per_q + 2'd1;
				end else begin
					fin = 1'b1;
					fin_kind = (per_q >= 2'd2) ? K_IDF : K_NBR;
					idle = 1'b1;
				end
			end
			M_LOGIC: begin
				if (is_logic(text_byte)) begin
					app = 1'b1;
				end else begin
					fin = 1'b1;
					fin_kind = K_LOP;
					idle = 1'b1;
				end
			end
			M_SLASH: begin
				if (text_byte == "/") begin
					mode_d = M_LINE;
				end else if (text_byte == "*") begin
					mode_d = M_BLOCK;
				end else begin
					fin = 1'b1;
					fin_kind = K_MOP;
					idle = 1'b1;
				end
			end
			M_LINE: begin
				if (text_byte == 8'd0)
					eof_c = 1'b1;
				else if (text_byte == 8'd10 || text_byte == 8'd13)
					mode_d = M_IDLE;
			end
			M_BLOCK: begin
				if (text_byte == 8'd0)
					eof_c = 1'b1;
				else if (text_byte == "*")
					mode_d = M_STAR;
			end
			M_STAR: begin
				if (text_byte == 8'd0)
					eof_c = 1'b1;
				else if (text_byte == "/")
					mode_d = M_IDLE;
				else if (text_byte != "*")
					mode_d = M_BLOCK;
			end
			default: begin
				idle = 1'b1;
			end
		endcase

		if (app) begin
			if (run_q < LEN_W'(LEN_CAP)) begin
				if (run_q < LEN_W'(KEYWORD_CHARS))
					win_d[{run_q[2:0], 3'b000} +: 8] = text_byte;
				run_d = run_q + LEN_W'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end

		if (fin)
			mode_d = M_IDLE;

		if (idle) begin
			if (text_byte == 8'd0) begin
				eof_c = 1'b1;
			end else if (is_blank(text_byte)) begin
				mode_d = M_IDLE;
			end else if (is_letter(text_byte)) begin
				beg = 1'b1;
				beg_mode = M_IDENT;
			end else if (is_digit(text_byte)) begin
				beg = 1'b1;
				beg_mode = M_NUMBER;
			end else if (text_byte == "/") begin
				beg = 1'b1;
				beg_mode = M_SLASH;
			end else if (is_sep(text_byte)) begin
				idle_res = 1'b1;
				idle_kind = K_SPR;
			end else if (is_logic(text_byte)) begin
				beg = 1'b1;
				beg_mode = M_LOGIC;
			end else if (is_math(text_byte)) begin
				idle_res = 1'b1;
				idle_kind = K_MOP;
			end else begin
				idle_res = 1'b1;
				idle_kind = K_IDF;
			end
		end

		if (beg) begin
			mode_d = beg_mode;
			start_d = pos_q;
			run_d = LEN_W'(1);
			ovf_d = 1'b0;
			per_d = 2'd0;
			win_d[7:0] = text_byte;
		end

		if (eof_c)
			mode_d = M_IDLE;

		pos_d = (text_byte == 8'd0) ? 32'd0 : pos_q + 32'd1;
	end

	// Results: the finished token first, then the one-character or eof token
	always_comb begin
		fin_tok.kind = fin_kind;
		fin_tok.offset = start_q;
		fin_tok.length = run_q;
		fin_tok.overflow = ovf_q;
		fin_tok.last = !(idle_res || eof_c);

		second_tok.kind = eof_c ? K_EOF : idle_kind;
		second_tok.offset = pos_q;
		second_tok.length = eof_c ? LEN_W'(0) : LEN_W'(1);
		second_tok.overflow = 1'b0;
		second_tok.last = 1'b1;

		res.tok0 = fin ? fin_tok : second_tok;
		res.tok1 = second_tok;
		res.count = 2'(fin) + 2'(idle_res || eof_c);
		if (!step)
			res.count = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (step)
			win_q <= win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q <= '0;
			start_q <= '0;
			run_q <= '0;
			per_q <= '0;
			ovf_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			start_q <= start_d;
			run_q <= run_d;
			per_q <= per_d;
			ovf_q <= ovf_d;
		end
	end

endmodule

// ===== rtl/core/script_tokenizer.sv =====
// Script tokenizer: one text byte per cycle in while text_stall is low; up to two
// tokens per byte out. A byte is registered in byte_s1, stepped through the lexer
// into the result queue, and its first token is offered at the queue head.
// Throughput: one byte per cycle while each byte yields at most one token and the
// output is not stalled; bytes that close a token and yield a second one fill the
// four-entry result queue faster than the single-token output port drains it.
// Reset: arst_n clears the lexer mode, offsets, counters and the queue at once.
module script_tokenizer
	import sctok_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             text_valid,
	output logic             text_stall,
	input  logic [7:0]       text_byte,
	output logic             token_valid,
	input  logic             token_stall,
	output logic [2:0]       token_kind,
	output logic [31:0]      token_offset,
	output logic [LEN_W-1:0] token_length,
	output logic             length_overflow,
	output logic             last_of_run
);

	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       room;
	logic       step;
	logic       load;
	step_res_t  res;
	token_t     head;

	assign step = valid_s1 && room;
	assign text_stall = valid_s1 && !room;
	assign load = text_valid && !text_stall;

	always_ff @(posedge clk) begin
		if (load)
			byte_s1 <= text_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	sctok_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_byte (byte_s1),
		.res       (res)
	);

	sctok_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (res.count),
		.push_tok0 (res.tok0),
		.push_tok1 (res.tok1),
		.pop       (token_valid && !token_stall),
		.room      (room),
		.not_empty (token_valid),
		.head      (head)
	);

	assign token_kind = head.kind;
	assign token_offset = head.offset;
	assign token_length = head.length;
	assign length_overflow = head.overflow;
	assign last_of_run = head.last;

endmodule

// ===== tb/script_tokenizer_chk.sv =====
// Token checker: tracks accepted text bytes, predicts the tokens they cause and compares results.
module script_tokenizer_chk
	import sctok_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             text_valid,
	input  logic             text_stall,
	input  logic [7:0]       text_byte,
	input  logic             token_valid,
	input  logic             token_stall,
	input  logic [2:0]       token_kind,
	input  logic [31:0]      token_offset,
	input  logic [LEN_W-1:0] token_length,
	input  logic             length_overflow,
	input  logic             last_of_run,
	output int               pending,
	output int               errors,
	output int               tokens_checked
);

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	mode_t            lex_mode;
	logic [31:0]      byte_pos;
	logic [31:0]      tok_start;
	logic [LEN_W-1:0] tok_len;
	logic [7:0]       word_buf [KEYWORD_CHARS];
	logic [1:0]       dots;
	logic             tok_ovf;
	token_t           byte_tokens [$];
	token_t           token_fifo [$];
	int               mismatches = 0;
	int               compared = 0;

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c inside {8'd32, 8'd9, CH_LF, 8'd11, CH_CR};
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		return c inside {"{", "}", "(", ")", "[", "]", ":", ";", ",", 8'h22, 8'h27};
	endfunction

	function automatic logic is_rel(logic [7:0] c);
		return c inside {">", "<", "=", "&", "|", "%"};
	endfunction

	function automatic logic is_arith(logic [7:0] c);
		return c inside {"+", "-", "*", "^"};
	endfunction

	// Words pack right-justified; they never hold a zero byte, so length is implied.
	function automatic logic [2:0] word_class();
		logic [63:0] w;
		w = '0;
		if (tok_ovf || tok_len > KEYWORD_CHARS)
			return K_IDF;
		for (int j = 0; j < KEYWORD_CHARS; j++)
			if (j < tok_len)
				w = {w[55:0], word_buf[j]};
		case (w)
			"function", "var": return K_DEF;
			"for", "foreach", "else", "event", "do", "if", "body", "while", "header",
			"document": return K_BHD;
			default: return K_IDF;
		endcase
	endfunction

	task automatic add_token(input logic [2:0] kind, input logic [31:0] off,
			input logic [LEN_W-1:0] len, input logic ovf);
		token_t t;
		t.kind = kind;
		t.offset = off;
		t.length = len;
		t.overflow = ovf;
		t.last = 1'b0;
		byte_tokens.push_back(t);
	endtask

	task automatic open_token(input logic [7:0] c, input mode_t m);
		lex_mode = m;
		tok_start = byte_pos;
		tok_len = LEN_W'(1);
		tok_ovf = 1'b0;
		dots = '0;
		word_buf[0] = c;
	endtask

	task automatic grow_token(input logic [7:0] c);
		if (tok_len < LEN_CAP) begin
			if (tok_len < KEYWORD_CHARS)
				word_buf[tok_len] = c;
			tok_len = tok_len + 1'b1;
		end else begin
			tok_ovf = 1'b1;
		end
	endtask

	task automatic close_token(input logic [2:0] kind);
		add_token(kind, tok_start, tok_len, tok_ovf);
		lex_mode = M_IDLE;
	endtask

	task automatic end_text();
		add_token(K_EOF, byte_pos, '0, 1'b0);
		lex_mode = M_IDLE;
	endtask

	task automatic idle_byte(input logic [7:0] c);
		if (c == CH_NUL)
			end_text();
		else if (is_space(c))
			lex_mode = M_IDLE;
		else if (is_alpha(c))
			open_token(c, M_IDENT);
		else if (is_num(c))
			open_token(c, M_NUMBER);
		else if (c == "/")
			open_token(c, M_SLASH);
		else if (is_punct(c))
			add_token(K_SPR, byte_pos, LEN_W'(1), 1'b0);
		else if (is_rel(c))
			open_token(c, M_LOGIC);
		else if (is_arith(c))
			add_token(K_MOP, byte_pos, LEN_W'(1), 1'b0);
		else
			add_token(K_IDF, byte_pos, LEN_W'(1), 1'b0);
	endtask

	task automatic predict(input logic [7:0] c);
		token_t t;
		byte_tokens.delete();
		case (lex_mode)
			M_IDENT: begin
				if (is_alpha(c) || is_num(c) || c == ".") begin
					grow_token(c);
				end else begin
					close_token(word_class());
					idle_byte(c);
				end
			end
			M_NUMBER: begin
				if (is_num(c) || c == ".") begin
					// periods past the cap still count
					if (c == "." && dots < 2)
						dots = dots + 1'b1;
					grow_token(c);
				end else begin
					close_token(dots >= 2 ? K_IDF : K_NBR);
					idle_byte(c);
				end
			end
			M_LOGIC: begin
				if (is_rel(c)) begin
					grow_token(c);
				end else begin
					close_token(K_LOP);
					idle_byte(c);
				end
			end
			M_SLASH: begin
				if (c == "/") begin
					lex_mode = M_LINE;
				end else if (c == "*") begin
					lex_mode = M_BLOCK;
				end else begin
					close_token(K_MOP);
					idle_byte(c);
				end
			end
			M_LINE: begin
				if (c == CH_NUL)
					end_text();
				else if (c == CH_LF || c == CH_CR)
					lex_mode = M_IDLE;
			end
			M_BLOCK: begin
				if (c == CH_NUL)
					end_text();
				else if (c == "*")
					lex_mode = M_STAR;
			end
			M_STAR: begin
				if (c == CH_NUL)
					end_text();
				else if (c == "/")
					lex_mode = M_IDLE;
				else if (c != "*")
					lex_mode = M_BLOCK;
			end
			default: idle_byte(c);
		endcase
		foreach (byte_tokens[i]) begin
			t = byte_tokens[i];
			t.last = (i == byte_tokens.size() - 1);
			token_fifo.push_back(t);
		end
		byte_pos = (c == CH_NUL) ? '0 : byte_pos + 1;
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: token %s mismatch: expected %0d, actual %0d", $time, what,
				exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		token_t want;
		if (!arst_n) begin
			lex_mode = M_IDLE;
			byte_pos = '0;
			tok_start = '0;
			tok_len = '0;
			dots = '0;
			tok_ovf = 1'b0;
			token_fifo.delete();
		end else begin
			if (token_valid && !token_stall) begin
				compared++;
				if (token_fifo.size() == 0) begin
					mismatches++;
					$display("%0t: token with nothing expected: kind %0d offset %0d length %0d",
						$time, token_kind, token_offset, token_length);
				end else begin
					want = token_fifo.pop_front();
					check_field("kind", 32'(want.kind), 32'(token_kind));
					check_field("offset", want.offset, token_offset);
					check_field("length", 32'(want.length), 32'(token_length));
					check_field("overflow", 32'(want.overflow), 32'(length_overflow));
					check_field("last", 32'(want.last), 32'(last_of_run));
				end
			end
			if (text_valid && !text_stall)
				predict(text_byte);
		end
		pending <= token_fifo.size();
		errors <= mismatches;
		tokens_checked <= compared;
	end

endmodule

// ===== tb/script_tokenizer_tb.sv =====
// Testbench top for the script tokenizer: clock, reset, byte stimulus, token stalls and verdict.
module script_tokenizer_tb;
	import sctok_pkg::*;

	localparam int RANDOM_BYTES = 500;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int LONG_RUN = LEN_CAP + 1;

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             text_valid = 1'b0;
	logic             text_stall;
	logic [7:0]       text_byte = 8'd0;
	logic             token_valid;
	logic             token_stall = 1'b0;
	logic [2:0]       token_kind;
	logic [31:0]      token_offset;
	logic [LEN_W-1:0] token_length;
	logic             length_overflow;
	logic             last_of_run;
	logic             calm = 1'b0;
	int               pending;
	int               errors;
	int               tokens_checked;
	int               bytes_sent = 0;
	int               texts_sent = 0;

	script_tokenizer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_valid      (text_valid),
		.text_stall      (text_stall),
		.text_byte       (text_byte),
		.token_valid     (token_valid),
		.token_stall     (token_stall),
		.token_kind      (token_kind),
		.token_offset    (token_offset),
		.token_length    (token_length),
		.length_overflow (length_overflow),
		.last_of_run     (last_of_run)
	);

	script_tokenizer_chk chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_valid      (text_valid),
		.text_stall      (text_stall),
		.text_byte       (text_byte),
		.token_valid     (token_valid),
		.token_stall     (token_stall),
		.token_kind      (token_kind),
		.token_offset    (token_offset),
		.token_length    (token_length),
		.length_overflow (length_overflow),
		.last_of_run     (last_of_run),
		.pending         (pending),
		.errors          (errors),
		.tokens_checked  (tokens_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		token_stall <= !calm && ($urandom_range(99) < 33);
	end

	function automatic logic [7:0] rand_letter();
		return $urandom_range(1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
	endfunction

	function automatic logic [7:0] rand_word_char();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return rand_letter();
		else if (r < 85)
			return 8'($urandom_range(48, 57));
		return ".";
	endfunction

	function automatic logic [7:0] pick(input string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	function automatic string keyword(input int i);
		case (i)
			0: return "function";
			1: return "var";
			2: return "for";
			3: return "foreach";
			4: return "else";
			5: return "event";
			6: return "do";
			7: return "if";
			8: return "body";
			9: return "while";
			10: return "header";
			default: return "document";
		endcase
	endfunction

	// Valid is held until the item is taken; the stall seen here is the pre-edge value.
	task automatic send_byte(input logic [7:0] b);
		while (!calm && $urandom_range(99) < 33) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (text_stall);
		bytes_sent++;
		if (b == CH_NUL)
			texts_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic drain();
		text_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_piece();
		int         sel;
		int         n;
		logic [7:0] c;
		string      k;
		sel = $urandom_range(99);
		if (sel < 18) begin
			// keyword, cut short, extended or capitalized
			k = keyword($urandom_range(11));
			n = $urandom_range(3);
			for (int i = 0; i < k.len(); i++) begin
				c = k[i];
				if (n == 3 && i == 0)
					c = c - 8'd32;
				if (!(n == 1 && i == k.len() - 1))
					send_byte(c);
			end
			if (n == 2)
				send_byte(rand_word_char());
			if ($urandom_range(3) != 0)
				send_byte(pick(" (;"));
		end else if (sel < 32) begin
			send_byte(rand_letter());
			repeat ($urandom_range(9)) send_byte(rand_word_char());
		end else if (sel < 44) begin
			send_byte(8'($urandom_range(48, 57)));
			repeat ($urandom_range(7))
				send_byte($urandom_range(4) == 0 ? 8'h2e : 8'($urandom_range(48, 57)));
		end else if (sel < 52) begin
			repeat ($urandom_range(1, 4)) send_byte(pick("><=&|%"));
		end else if (sel < 58) begin
			send_byte(pick("{}()[]:;,\"'"));
		end else if (sel < 64) begin
			send_byte(pick("+-*^"));
		end else if (sel < 78) begin
			repeat ($urandom_range(1, 3)) send_byte(pick("\040\011\012\013\015"));
		end else if (sel < 83) begin
			send_text("//");
			repeat ($urandom_range(8)) begin
				c = 8'($urandom_range(1, 255));
				if (c == CH_LF || c == CH_CR)
					c = "#";
				send_byte(c);
			end
			send_byte($urandom_range(1) ? CH_LF : CH_CR);
		end else if (sel < 88) begin
			// star-heavy body so close pairs and false closes both show up
			send_text("/*");
			repeat ($urandom_range(8)) begin
				n = $urandom_range(99);
				send_byte(n < 40 ? 8'h2a : n < 55 ? 8'h2f : 8'($urandom_range(1, 255)));
			end
			send_text("*/");
		end else if (sel < 91) begin
			send_byte("/");
		end else if (sel < 96) begin
			send_byte(8'($urandom_range(1, 255)));
		end else if (sel < 98) begin
			send_byte(CH_NUL);
		end else begin
			// text ends inside a comment
			send_byte("/");
			send_byte($urandom_range(1) ? "*" : "/");
			repeat ($urandom_range(3)) send_byte(8'($urandom_range(1, 255)));
			send_byte(CH_NUL);
		end
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_valid && !text_stall) || (token_valid && !token_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		int base;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("for;a.1/2/*/*/%=3..4//\n!");
		send_byte(CH_NUL);
		send_text("var-");
		send_byte(8'hff);
		send_text("\t/*");
		send_byte(CH_NUL);
		drain();

		base = bytes_sent;
		while (bytes_sent - base < RANDOM_BYTES) begin
			calm <= (bytes_sent - base >= 150) && (bytes_sent - base < 300);
			send_piece();
		end
		calm <= 1'b0;
		send_byte(CH_NUL);
		drain();

		// number past the length cap whose second period lands after the cap
		for (int i = 2; i < LONG_RUN; i++)
			send_byte(8'($urandom_range(48, 57)));
		send_text("..");
		send_byte(CH_NUL);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run: %0d text bytes in %0d texts, %0d tokens compared.", bytes_sent,
			texts_sent, tokens_checked);
		$display("Covered keywords and near misses, comments, lone slashes, numbers, logic runs, noise bytes and capped tokens.");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
